[src/assert_macros.svh]
// Assertion macros for the RTL of the node supervisor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising edge outside reset.
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at each rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/cnmes_pkg.sv]
// Types, codes and helpers for the CAN node mode and error-state supervisor.
package cnmes_pkg;

    localparam int RX_W   = 8;
    localparam int TX_W   = 9;
    localparam int MODE_W = 3;
    localparam int RES_W  = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_PASSIVE_LIMIT = 2'd0;
    localparam logic [IDX_W-1:0] CFG_BUSOFF_LIMIT  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_RESUME_TICKS  = 2'd2;

    // Configuration reset values
    localparam logic [RX_W-1:0]  PASSIVE_LIMIT_RST = 8'd127;
    localparam logic [TX_W-1:0]  BUSOFF_LIMIT_RST  = 9'd255;
    localparam logic [RES_W-1:0] RESUME_TICKS_RST  = 16'd65535;

    // Output codes of the node mode
    localparam logic [MODE_W-1:0] NM_OFF      = 3'd0;
    localparam logic [MODE_W-1:0] NM_STARTUP  = 3'd1;
    localparam logic [MODE_W-1:0] NM_NORMAL   = 3'd2;
    localparam logic [MODE_W-1:0] NM_BUSERR   = 3'd3;
    localparam logic [MODE_W-1:0] NM_SHUTDOWN = 3'd4;

    // Output codes of the error state
    localparam logic [MODE_W-1:0] EM_INIT    = 3'd0;
    localparam logic [MODE_W-1:0] EM_NORMAL  = 3'd1;
    localparam logic [MODE_W-1:0] EM_ACTIVE  = 3'd2;
    localparam logic [MODE_W-1:0] EM_PASSIVE = 3'd3;
    localparam logic [MODE_W-1:0] EM_BUSOFF  = 3'd4;

    typedef enum logic [4:0] {
        NS_OFF      = 5'b00001,
        NS_STARTUP  = 5'b00010,
        NS_NORMAL   = 5'b00100,
        NS_BUSERR   = 5'b01000,
        NS_SHUTDOWN = 5'b10000
    } t_node_state;

    typedef enum logic [4:0] {
        ES_INIT    = 5'b00001,
        ES_NORMAL  = 5'b00010,
        ES_ACTIVE  = 5'b00100,
        ES_PASSIVE = 5'b01000,
        ES_BUSOFF  = 5'b10000
    } t_err_state;

    typedef struct packed {
        logic [MODE_W-1:0] node_mode;
        logic [MODE_W-1:0] error_mode;
        logic              stop_controller;
        logic              init_controller;
        logic              start_controller;
        logic              busoff_notify;
    } t_out_item;

    function automatic logic [MODE_W-1:0] node_code(input t_node_state s);
        logic [MODE_W-1:0] c;
        case (s)
            NS_STARTUP:  c = NM_STARTUP;
            NS_NORMAL:   c = NM_NORMAL;
            NS_BUSERR:   c = NM_BUSERR;
            NS_SHUTDOWN: c = NM_SHUTDOWN;
            default:     c = NM_OFF;
        endcase
        return c;
    endfunction

    function automatic logic [MODE_W-1:0] err_code(input t_err_state s);
        logic [MODE_W-1:0] c;
        case (s)
            ES_NORMAL:  c = EM_NORMAL;
            ES_ACTIVE:  c = EM_ACTIVE;
            ES_PASSIVE: c = EM_PASSIVE;
            ES_BUSOFF:  c = EM_BUSOFF;
            default:    c = EM_INIT;
        endcase
        return c;
    endfunction

endpackage

[src/cnmes_in_if.sv]
// Input channel: one tick of ignition level and controller error counts.
interface cnmes_in_if;
    logic                       valid;
    logic                       ready;
    logic                       ignition_on;
    logic [cnmes_pkg::RX_W-1:0] rx_error_count;
    logic [cnmes_pkg::TX_W-1:0] tx_error_count;

    modport source (output valid, output ignition_on, output rx_error_count,
                    output tx_error_count, input ready);
    modport sink   (input valid, input ignition_on, input rx_error_count,
                    input tx_error_count, output ready);
endinterface

[src/cnmes_out_if.sv]
// Output channel: modes and controller commands for one tick.
interface cnmes_out_if;
    logic                         valid;
    logic                         ready;
    logic [cnmes_pkg::MODE_W-1:0] node_mode;
    logic [cnmes_pkg::MODE_W-1:0] error_mode;
    logic                         stop_controller;
    logic                         init_controller;
    logic                         start_controller;
    logic                         busoff_notify;

    modport source (output valid, output node_mode, output error_mode,
                    output stop_controller, output init_controller,
                    output start_controller, output busoff_notify, input ready);
    modport sink   (input valid, input node_mode, input error_mode,
                    input stop_controller, input init_controller,
                    input start_controller, input busoff_notify, output ready);
endinterface

[src/can_node_mode_and_error_state.sv]
// CAN node mode and error-state supervisor: top level.
//
// One transfer on i_in is one tick: the ignition level and the receive and
// transmit error counts read from the CAN controller. For each tick the block
// returns one transfer on o_out with the node mode (off, startup, normal,
// bus error, shutdown), the fault confinement state (init, normal, error
// active, error passive, bus-off), the stop / init / start commands for the
// controller and a one-tick bus-off notify pulse. The node-mode machine sees
// the error state left by the previous tick; the error state then steps
// through normal, active, passive and bus-off in that order within one tick,
// so a single tick can go from normal all the way to bus-off. Bus-off counts
// ticks from one at the entry tick and returns to error active on the tick
// whose count reaches resume_ticks. The block takes one tick per clock cycle
// as long as o_out takes each result: a tick is captured in an input register,
// the whole state update is one short combinational pass into the result
// register, and the result is shown from there on o_out. The input register
// and the result register form a two-entry pipeline, so a new tick is still
// taken while one result waits.
// Write i_cfg_* only while no tick is in flight; index 0 is passive_limit,
// 1 busoff_limit, 2 resume_ticks, and other indexes are ignored. No memory,
// no clearing pass after reset.

`include "assert_macros.svh"

module can_node_mode_and_error_state (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cnmes_in_if.sink                      i_in,
    cnmes_out_if.source                   o_out,
    input  logic                          i_cfg_we,
    input  logic [cnmes_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [cnmes_pkg::CFG_W-1:0]   i_cfg_data
);

    // Configuration registers
    logic [cnmes_pkg::RX_W-1:0]  r_passive_limit;
    logic [cnmes_pkg::TX_W-1:0]  r_busoff_limit;
    logic [cnmes_pkg::RES_W-1:0] r_resume_ticks;

    // Supervisor state
    cnmes_pkg::t_node_state      r_node, n_node;
    cnmes_pkg::t_err_state       r_err, n_err;
    logic [cnmes_pkg::RES_W-1:0] r_resume_cnt, n_resume_cnt;

    // Input stage
    logic                        r_in_valid;
    logic                        r_in_ign;
    logic [cnmes_pkg::RX_W-1:0]  r_in_rx;
    logic [cnmes_pkg::TX_W-1:0]  r_in_tx;

    // Result stage
    logic                        r_out_valid;
    cnmes_pkg::t_out_item        r_out, n_out;

    logic                        advance;
    logic                        process;

    // The result stage frees when empty or taken; the input stage frees when
    // empty or moving on.
    assign advance    = !r_out_valid || o_out.ready;
    assign process    = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_passive_limit <= cnmes_pkg::PASSIVE_LIMIT_RST;
            r_busoff_limit  <= cnmes_pkg::BUSOFF_LIMIT_RST;
            r_resume_ticks  <= cnmes_pkg::RESUME_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cnmes_pkg::CFG_PASSIVE_LIMIT: begin
                    r_passive_limit <= i_cfg_data[cnmes_pkg::RX_W-1:0];
                end
                cnmes_pkg::CFG_BUSOFF_LIMIT: begin
                    r_busoff_limit <= i_cfg_data[cnmes_pkg::TX_W-1:0];
                end
                cnmes_pkg::CFG_RESUME_TICKS: begin
                    r_resume_ticks <= i_cfg_data[cnmes_pkg::RES_W-1:0];
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // One tick of both machines
    // ------------------------------------------------------------------
    always_comb begin
        logic                        stop;
        logic                        init;
        logic                        start;
        logic                        notify;
        logic                        prev_busoff;
        logic [cnmes_pkg::RX_W-1:0]  rx;
        logic [cnmes_pkg::TX_W-1:0]  tx;
        logic                        rx_over;
        logic                        tx_over;
        logic [cnmes_pkg::RES_W-1:0] cnt_inc;
        cnmes_pkg::t_err_state       es;

        stop        = 1'b0;
        init        = 1'b0;
        start       = 1'b0;
        notify      = 1'b0;
        prev_busoff = (r_err == cnmes_pkg::ES_BUSOFF);
        n_node      = r_node;

        // Node mode: uses the error state of the previous tick
        case (r_node)
            cnmes_pkg::NS_OFF: begin
                if (r_in_ign) begin
                    n_node = cnmes_pkg::NS_STARTUP;
                    init   = 1'b1;
                    start  = 1'b1;
                end else begin
                    stop = 1'b1;
                end
            end
            cnmes_pkg::NS_STARTUP: begin
                n_node = cnmes_pkg::NS_NORMAL;
            end
            cnmes_pkg::NS_NORMAL: begin
                if (!r_in_ign) begin
                    n_node = cnmes_pkg::NS_SHUTDOWN;
                    stop   = 1'b1;
                end else if (prev_busoff) begin
                    n_node = cnmes_pkg::NS_BUSERR;
                    stop   = 1'b1;
                    init   = 1'b1;
                end
            end
            cnmes_pkg::NS_BUSERR: begin
                if (!r_in_ign) begin
                    n_node = cnmes_pkg::NS_SHUTDOWN;
                    stop   = 1'b1;
                end else if (!prev_busoff) begin
                    n_node = cnmes_pkg::NS_STARTUP;
                    init   = 1'b1;
                    start  = 1'b1;
                end
            end
            default: begin
                // shutdown: back to off
                n_node = cnmes_pkg::NS_OFF;
                stop   = 1'b1;
            end
        endcase

        // Error state: fall through the steps in order
        es = r_err;
        rx = r_in_rx;
        tx = r_in_tx;
        if (es != cnmes_pkg::ES_NORMAL && es != cnmes_pkg::ES_ACTIVE &&
            es != cnmes_pkg::ES_PASSIVE && es != cnmes_pkg::ES_BUSOFF) begin
            // init ignores this tick's counts
            rx = '0;
            tx = '0;
            es = cnmes_pkg::ES_NORMAL;
        end

        rx_over = (rx > r_passive_limit);
        tx_over = (tx > {1'b0, r_passive_limit});

        if (es == cnmes_pkg::ES_NORMAL) begin
            if (rx != '0 || tx != '0) begin
                es = cnmes_pkg::ES_ACTIVE;
            end
        end
        if (es == cnmes_pkg::ES_ACTIVE) begin
            if (rx_over || tx_over) begin
                es = cnmes_pkg::ES_PASSIVE;
            end else if (rx == '0 && tx == '0) begin
                es = cnmes_pkg::ES_NORMAL;
            end
        end
        if (es == cnmes_pkg::ES_PASSIVE) begin
            if (!rx_over && !tx_over) begin
                es = cnmes_pkg::ES_ACTIVE;
            end else if (tx > r_busoff_limit) begin
                es     = cnmes_pkg::ES_BUSOFF;
                notify = 1'b1;
            end
        end

        // Bus-off: count ticks, the entry tick included, up to resume_ticks
        cnt_inc      = r_resume_cnt + 16'd1;
        n_resume_cnt = r_resume_cnt;
        if (es == cnmes_pkg::ES_BUSOFF) begin
            if (cnt_inc >= r_resume_ticks) begin
                es           = cnmes_pkg::ES_ACTIVE;
                n_resume_cnt = '0;
            end else begin
                n_resume_cnt = cnt_inc;
            end
        end
        n_err = es;

        n_out.node_mode        = cnmes_pkg::node_code(n_node);
        n_out.error_mode       = cnmes_pkg::err_code(n_err);
        n_out.stop_controller  = stop;
        n_out.init_controller  = init;
        n_out.start_controller = start;
        n_out.busoff_notify    = notify;
    end

    // ------------------------------------------------------------------
    // Pipeline and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_node       <= cnmes_pkg::NS_OFF;
            r_err        <= cnmes_pkg::ES_INIT;
            r_resume_cnt <= '0;
        end else begin
            // input stage: load on transfer, empty when moving on
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end
            // result stage: reload when free
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            // advance state only when a tick is processed
            if (process) begin
                r_node       <= n_node;
                r_err        <= n_err;
                r_resume_cnt <= n_resume_cnt;
            end
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_ign <= i_in.ignition_on;
            r_in_rx  <= i_in.rx_error_count;
            r_in_tx  <= i_in.tx_error_count;
        end
        if (process) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.node_mode        = r_out.node_mode;
    assign o_out.error_mode       = r_out.error_mode;
    assign o_out.stop_controller  = r_out.stop_controller;
    assign o_out.init_controller  = r_out.init_controller;
    assign o_out.start_controller = r_out.start_controller;
    assign o_out.busoff_notify    = r_out.busoff_notify;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the resume counter only runs in bus-off and is cleared on leaving it
    `ASSERT_NOW(a_resume_idle, r_err != cnmes_pkg::ES_BUSOFF, r_resume_cnt == '0)
    // startup always moves on to normal at the next processed tick
    `ASSERT_NEXT(a_startup_next, process && r_node == cnmes_pkg::NS_STARTUP,
        r_node == cnmes_pkg::NS_NORMAL)
    // a stop command never comes with a start command
    `ASSERT_NOW(a_stop_start, r_out_valid,
        !(r_out.stop_controller && r_out.start_controller))

endmodule
